FILE: hw/rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // Write enables toward the entry store.
  typedef struct packed {
    logic key_we;
    logic val_we;
    logic rank_we;
  } mem_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lkvc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkvc_req_if
  import lkvc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [KEY_W-1:0] lookup_key;
  logic [VAL_W-1:0] store_value;

  modport source (output valid, output operation, output lookup_key, output store_value,
                  input ready);
  modport sink (input valid, input operation, input lookup_key, input store_value,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lkvc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkvc_rsp_if
  import lkvc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [VAL_W-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink (input valid, input hit, input read_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lkvc_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkvc_cfg_if
  import lkvc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_limit;

  modport source (output valid, output capacity_limit, input ready);
  modport sink (input valid, input capacity_limit, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
// req (sink): one get (operation 0) or set (operation 1) per transfer, with
//   lookup_key and, for a set, store_value.
// rsp (source): exactly one result per request, in order: hit, and read_value
//   (the stored value on a get hit, all ones otherwise).
// cfg (sink): capacity_limit, always ready; write it only while no request
//   is in flight. Zero acts as one, values above DEPTH act as DEPTH.
// One request at a time: a single comparator/incrementer walks the entries
//   through one memory read port, one entry per cycle. A request runs a key
//   scan over the filled entries, then a recency sweep over them on any hit
//   or set, then posts the result.
// req.ready is high only while the sequencer is idle.
// Results sit in an output register; a request can be accepted while the
//   previous result still waits, and the sequencer holds its result until
//   the register frees up, so a stalled receiver only delays, never drops.
// Reset (rst, synchronous) empties the cache, sets capacity to 16 and drops
//   any pending result. Entry memories are not cleared; only filled entries
//   are ever used.
module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  lkvc_req_if.sink  req,
  lkvc_rsp_if.source rsp,
  lkvc_cfg_if.sink  cfg
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CAP_W-1:0] capacity_limit;
  logic [CNT_W-1:0] cap_eff;
  logic             rsp_valid;
  logic             rsp_hit;
  logic [VAL_W-1:0] rsp_value;
  logic             out_free;
  logic             idle;
  logic             done;
  logic             res_hit;
  logic [VAL_W-1:0] res_value;
  mem_wr_t          wr;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [VAL_W-1:0] wr_val;
  logic [IDX_W-1:0] wr_rank;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [IDX_W-1:0] rank_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity_limit <= cfg.capacity_limit;
    end
  end

  always_comb begin
    if (capacity_limit == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity_limit) > 32'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity_limit);
    end
  end

  assign req.ready = idle;
  assign out_free  = !rsp_valid || rsp.ready;

  lkvc_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (req.valid),
    .op_in    (req.operation),
    .key_in   (req.lookup_key),
    .val_in   (req.store_value),
    .cap_eff  (cap_eff),
    .out_free (out_free),
    .idle     (idle),
    .done     (done),
    .hit      (res_hit),
    .value    (res_value),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_val   (wr_val),
    .wr_rank  (wr_rank),
    .rd_addr  (rd_addr),
    .key_q    (key_q),
    .val_q    (val_q),
    .rank_q   (rank_q)
  );

  lkvc_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_val  (wr_val),
    .wr_rank (wr_rank),
    .rd_addr (rd_addr),
    .key_q   (key_q),
    .val_q   (val_q),
    .rank_q  (rank_q)
  );

  // Output register: load on done, drop after the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
      rsp_hit   <= res_hit;
      rsp_value <= res_value;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_value;

endmodule

`default_nettype wire

FILE: hw/rtl/lkvc_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvc_mem
  import lkvc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire mem_wr_t          wr,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [KEY_W-1:0] wr_key,
  input  wire logic [VAL_W-1:0] wr_val,
  input  wire logic [IDX_W-1:0] wr_rank,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [KEY_W-1:0] key_q,
  output logic      [VAL_W-1:0] val_q,
  output logic      [IDX_W-1:0] rank_q
);

  logic [KEY_W-1:0] key_mem  [DEPTH];
  logic [VAL_W-1:0] val_mem  [DEPTH];
  logic [IDX_W-1:0] rank_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr.val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (wr.rank_we) begin
      rank_mem[wr_addr] <= wr_rank;
    end
  end

  always_ff @(posedge clk) begin
    key_q  <= key_mem[rd_addr];
    val_q  <= val_mem[rd_addr];
    rank_q <= rank_mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl
  import lkvc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             op_in,
  input  wire logic [KEY_W-1:0] key_in,
  input  wire logic [VAL_W-1:0] val_in,
  input  wire logic [CNT_W-1:0] cap_eff,
  input  wire logic             out_free,
  output logic                  idle,
  output logic                  done,
  output logic                  hit,
  output logic      [VAL_W-1:0] value,
  output mem_wr_t               wr,
  output logic      [IDX_W-1:0] wr_addr,
  output logic      [KEY_W-1:0] wr_key,
  output logic      [VAL_W-1:0] wr_val,
  output logic      [IDX_W-1:0] wr_rank,
  output logic      [IDX_W-1:0] rd_addr,
  input  wire logic [KEY_W-1:0] key_q,
  input  wire logic [VAL_W-1:0] val_q,
  input  wire logic [IDX_W-1:0] rank_q
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    DECIDE,
    UPDATE,
    FINISH
  } state_t;

  state_t           state;
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic             found;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] hit_rank;
  logic [VAL_W-1:0] hit_val;
  logic [IDX_W-1:0] best;
  logic [IDX_W-1:0] best_rank;
  logic             fill;
  logic [IDX_W-1:0] target;
  logic [IDX_W-1:0] pivot;

  logic issue;
  logic room;

  assign issue   = (idx < count);
  assign room    = (count < cap_eff);
  assign rd_addr = idx[IDX_W-1:0];
  assign idle    = (state == IDLE);
  assign done    = (state == FINISH) && out_free;
  assign hit     = found;
  assign value   = (op_r == OP_GET && found) ? hit_val : MISS_VALUE;
  assign wr_key  = key_r;
  assign wr_val  = val_r;

  always_comb begin
    wr      = '0;
    wr_addr = pend_idx;
    wr_rank = '0;
    case (state)
      DECIDE: begin
        if (found) begin
          wr.val_we = (op_r == OP_SET);
          wr_addr   = slot;
        end else if (op_r == OP_SET) begin
          wr.key_we = 1'b1;
          wr.val_we = 1'b1;
          if (room) begin
            wr.rank_we = 1'b1;
            wr_addr    = count[IDX_W-1:0];
          end else begin
            wr_addr = best;
          end
        end
      end
      UPDATE: begin
        if (pend) begin
          wr.rank_we = 1'b1;
          if (fill) begin
            wr_rank = rank_q + IDX_W'(1);
          end else if (pend_idx == target) begin
            wr_rank = '0;
          end else if (rank_q < pivot) begin
            wr_rank = rank_q + IDX_W'(1);
          end else begin
            wr_rank = rank_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
      fill  <= 1'b0;
      idx   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            op_r      <= op_in;
            key_r     <= key_in;
            val_r     <= val_in;
            idx       <= '0;
            pend      <= 1'b0;
            found     <= 1'b0;
            fill      <= 1'b0;
            best      <= '0;
            best_rank <= '0;
            state     <= SCAN;
          end
        end
        SCAN: begin
          // one entry read per cycle, compared the cycle after
          if (issue) begin
            idx      <= idx + CNT_W'(1);
            pend_idx <= idx[IDX_W-1:0];
          end
          pend <= issue;
          if (pend) begin
            if (key_q == key_r && !found) begin
              found    <= 1'b1;
              slot     <= pend_idx;
              hit_rank <= rank_q;
              hit_val  <= val_q;
            end
            if (rank_q > best_rank) begin
              best      <= pend_idx;
              best_rank <= rank_q;
            end
          end
          if (!issue && !pend) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          idx  <= '0;
          pend <= 1'b0;
          if (found) begin
            target <= slot;
            pivot  <= hit_rank;
            state  <= UPDATE;
          end else if (op_r == OP_SET) begin
            fill   <= room;
            target <= best;
            pivot  <= best_rank;
            state  <= UPDATE;
          end else begin
            state <= FINISH;
          end
        end
        UPDATE: begin
          if (issue) begin
            idx      <= idx + CNT_W'(1);
            pend_idx <= idx[IDX_W-1:0];
          end
          pend <= issue;
          if (!issue && !pend) begin
            if (fill) begin
              count <= count + CNT_W'(1);
            end
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && count != $past(count) |-> count == $past(count) + CNT_W'(1))
    else $error("entry count moved by other than one");

  a_get_miss_no_sweep: assert property (@(posedge clk) disable iff (rst)
    state == UPDATE |-> found || op_r == OP_SET)
    else $error("rank sweep started for a get miss");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    state == DECIDE && found |-> CNT_W'(slot) < count)
    else $error("matched slot beyond the filled entries");

  a_fill_room: assert property (@(posedge clk) disable iff (rst)
    state == DECIDE && !found && op_r == OP_SET && room |=> fill)
    else $error("new entry not marked as a fill");
`endif

endmodule

`default_nettype wire
